// ===== hw/rtl/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement core.
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int unsigned PageW    = 20;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned FaultW   = 32;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;

  localparam logic [FaultW-1:0] FaultMax = '1;

  typedef struct packed {
    logic [PageW-1:0] page;
    logic             last;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  frame_slot;
    logic              evicted_valid;
    logic [PageW-1:0]  evicted_page;
    logic [FaultW-1:0] fault_total;
    logic              sequence_done;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrupr_in_stage.sv =====
// Input register stage: holds one request word in front of the frame table.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  lrupr_pkg::req_t  req_i,
  input  logic             advance_i,
  output logic             valid_o,
  output lrupr_pkg::req_t  req_o
);

  logic            valid_q, valid_d;
  lrupr_pkg::req_t req_q;
  logic            load;

  // Take a new word when empty or when the held one moves on this cycle.
  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lrupr_frame_table.sv =====
// Frame table: resident pages, recency ranks, fill count and fault counter.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_frame_table #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lrupr_pkg::CfgW-1:0] frames_cfg_i,
  input  logic                       fire_i,
  input  lrupr_pkg::req_t            req_i,
  output lrupr_pkg::res_t            res_o
);

  localparam int unsigned IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = $clog2(MAX_FRAMES + 1);

  logic [lrupr_pkg::PageW-1:0]  page_q [MAX_FRAMES];
  logic [RankW-1:0]             rank_q [MAX_FRAMES];
  logic [RankW-1:0]             rank_d [MAX_FRAMES];
  logic [CntW-1:0]              filled_q, filled_d;
  logic [lrupr_pkg::FaultW-1:0] fault_q, fault_d;

  logic [CntW-1:0]       eff, window;
  logic [MAX_FRAMES-1:0] in_win, filled_v, match;
  logic                  hit, full, age_all;
  logic [IdxW-1:0]       hit_idx, victim, slot;
  logic [RankW-1:0]      sel_rank;
  logic [IdxW+lrupr_pkg::SlotW-1:0] slot_ext;

  // Clamp the frame count: zero acts as one, large values act as the maximum.
  always_comb begin
    if (frames_cfg_i == '0) begin
      eff = CntW'(1);
    end else if (32'(frames_cfg_i) > 32'(MAX_FRAMES)) begin
      eff = CntW'(MAX_FRAMES);
    end else begin
      eff = CntW'(frames_cfg_i);
    end
  end

  always_comb begin
    window = (filled_q < eff) ? filled_q : eff;
    full   = (filled_q >= eff);
    for (int k = 0; k < MAX_FRAMES; k++) begin
      in_win[k]   = (CntW'(k) < window);
      filled_v[k] = (CntW'(k) < filled_q);
      match[k]    = in_win[k] && (page_q[k] == req_i.page);
    end
  end

  // Lowest matching frame wins.
  always_comb begin
    hit     = |match;
    hit_idx = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = IdxW'(k);
      end
    end
  end

  // Oldest frame inside the search window.
  always_comb begin
    victim = '0;
    for (int j = 1; j < MAX_FRAMES; j++) begin
      if (in_win[j] && (rank_q[j] > rank_q[victim])) begin
        victim = IdxW'(j);
      end
    end
  end

  always_comb begin
    age_all = !hit && !full;
    priority if (hit) begin
      slot = hit_idx;
    end else if (!full) begin
      slot = filled_q[IdxW-1:0];
    end else begin
      slot = victim;
    end
    sel_rank = rank_q[slot];
  end

  // Promote the chosen frame; age every filled frame that was more recent.
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (IdxW'(k) == slot) begin
        rank_d[k] = '0;
      end else if (filled_v[k] && (age_all || (rank_q[k] < sel_rank))) begin
        rank_d[k] = rank_q[k] + RankW'(1);
      end else begin
        rank_d[k] = rank_q[k];
      end
    end
  end

  always_comb begin
    filled_d = age_all ? (filled_q + CntW'(1)) : filled_q;
    if (hit || (fault_q == lrupr_pkg::FaultMax)) begin
      fault_d = fault_q;
    end else begin
      fault_d = fault_q + lrupr_pkg::FaultW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      fault_q  <= '0;
      for (int k = 0; k < MAX_FRAMES; k++) begin
        rank_q[k] <= '0;
      end
    end else if (fire_i) begin
      if (req_i.last) begin
        filled_q <= '0;
        fault_q  <= '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
          rank_q[k] <= '0;
        end
      end else begin
        filled_q <= filled_d;
        fault_q  <= fault_d;
        for (int k = 0; k < MAX_FRAMES; k++) begin
          rank_q[k] <= rank_d[k];
        end
      end
    end
  end

  // Page store: no reset, only filled frames are ever compared or evicted.
  always_ff @(posedge clk_i) begin
    if (fire_i && !hit) begin
      page_q[slot] <= req_i.page;
    end
  end

  assign slot_ext = {{lrupr_pkg::SlotW{1'b0}}, slot};

  always_comb begin
    res_o.hit           = hit;
    res_o.frame_slot    = slot_ext[lrupr_pkg::SlotW-1:0];
    res_o.evicted_valid = !hit && full;
    res_o.evicted_page  = (!hit && full) ? page_q[victim] : '0;
    res_o.fault_total   = fault_d;
    res_o.sequence_done = req_i.last;
  end

  a_filled_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= 32'(MAX_FRAMES))
    else $error("fill count above frame count");

  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !req_i.last && !hit && !full |=> filled_q == $past(filled_q) + CntW'(1))
    else $error("fill count did not advance on append");

  a_seq_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.last |=> (filled_q == '0) && (fault_q == '0))
    else $error("state not cleared after last request");

  a_fault_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !req_i.last |=> fault_q >= $past(fault_q))
    else $error("fault count went down within a sequence");

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement core: ports, config register, result register.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       page number in tdata, last in tlast
//   m_axis    out        m_axis_tvalid/tready       slot, evicted page, faults; flags in tuser
//   cfg       in         cfg_valid_i/cfg_ready_o    frames in use (4 bits)
//
// One request per cycle while m_axis_tready is high; a request is held in the input register
// and its result in the result register. The lookup, victim search and rank update are
// combinational between the two; the victim search over the frame ranks sets the cycle time.
// A stalled result holds in the result register while the input register keeps one more word.
// Reset clears the frame table and sets frames in use to four; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [19:0] page_number, [23:20] zero
  input  logic [lrupr_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] frame_slot, [22:3] evicted_page, [54:23] fault_total, [55] zero
  output logic [lrupr_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] hit, [1] evicted_valid
  output logic [lrupr_pkg::OutUserW-1:0] m_axis_tuser,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrupr_pkg::CfgW-1:0]     cfg_data_i
);

  logic [lrupr_pkg::CfgW-1:0] frames_q;
  lrupr_pkg::req_t            s_req, req;
  lrupr_pkg::res_t            res, res_q;
  logic                       req_valid, advance, fire;
  logic                       out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::CfgW'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_q <= cfg_data_i;
    end
  end

  assign s_req.page = s_axis_tdata[lrupr_pkg::PageW-1:0];
  assign s_req.last = s_axis_tlast;

  // Result register drains or is empty: the held request may proceed.
  assign advance = !out_valid_q || m_axis_tready;
  assign fire    = req_valid && advance;

  lrupr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .req_i     (s_req),
    .advance_i (advance),
    .valid_o   (req_valid),
    .req_o     (req)
  );

  lrupr_frame_table #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_frame_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frames_cfg_i (frames_q),
    .fire_i       (fire),
    .req_i        (req),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.sequence_done;
  assign m_axis_tuser  = {res_q.evicted_valid, res_q.hit};
  assign m_axis_tdata  = {1'b0, res_q.fault_total, res_q.evicted_page, res_q.frame_slot};

endmodule

`default_nettype wire
